>>> rtl/i2cmbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

   // Command codes carried in the operation field.
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [15:0] RST_DELAY = 16'd100;
   localparam logic [15:0] WAIT_MAX  = 16'hFFFF;
   localparam logic [3:0]  ACK_SLOT  = 4'd8;
   localparam logic [2:0]  MSB_POS   = 3'd7;

endpackage

`default_nettype wire

>>> rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Contents
// req_*     in         req_valid / req_stall  one bus tick: command, byte, sensed lines
// rsp_*     out        rsp_valid / rsp_stall  line drive, busy, done, read byte, ack
// csr_*     in         csr_write_enable       delay_ticks, held in each bus phase
//
// Every accepted word is one bus tick and produces exactly one result word.
// The tick logic is a single pass from the state registers to the state registers, so
// one word is taken per cycle unless stalled; they are also the result register.
// Reset is synchronous and active high; it releases both lines and loads a delay of 100.
// While a result waits under rsp_stall the input is stalled, so the state holds it.

module i2c_master_byte_engine
   import i2cmbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd_valid,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_send_ack,
   input  wire logic        req_scl_sense,
   input  wire logic        req_sda_sense,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_pull_low,
   output logic             rsp_sda_pull_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_ack_received,

   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   // Bus phases. Start and stop each take three phases; every bit slot
   // (eight data slots and one acknowledge slot) takes set, high and low.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ST_A  = 4'd1,
      PH_ST_B  = 4'd2,
      PH_ST_C  = 4'd3,
      PH_SP_A  = 4'd4,
      PH_SP_B  = 4'd5,
      PH_SP_C  = 4'd6,
      PH_BSET  = 4'd7,
      PH_BHIGH = 4'd8,
      PH_BLOW  = 4'd9
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] wait_count_ff, wait_count_in;
   op_type      op_kind_ff, op_kind_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        ack_flag_ff, ack_flag_in;
   logic        scl_low_ff, scl_low_in;
   logic        sda_low_ff, sda_low_in;
   logic [7:0]  read_reg_ff, read_reg_in;
   logic        done_ff, done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] delay_ticks_ff;

   logic        req_accept;
   logic        stretch;
   logic [15:0] limit;
   logic [15:0] count_next;

   // SDA drive for a bit slot: a write sends the byte MSB first and releases
   // SDA for the slave's acknowledge; a read releases SDA for the data and
   // then drives the chosen ACK or NACK.
   function automatic logic slot_sda_pull(input op_type op, input logic [3:0] idx,
                                          input logic [7:0] data, input logic ack);
      logic pull;
      pull = 1'b0;
      if (op == OP_WRITE) begin
         if (idx < ACK_SLOT) begin
            pull = ~data[MSB_POS - idx[2:0]];
         end
      end else if (idx >= ACK_SLOT) begin
         pull = ack;
      end
      return pull;
   endfunction

   // A word moves on whenever the result slot is free or being drained.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // Phases that release SCL hold their count at zero while a slave stretches the clock.
   assign stretch = (phase_ff == PH_ST_A) || (phase_ff == PH_SP_B) ||
                    (phase_ff == PH_BHIGH);
   assign limit   = (delay_ticks_ff == 16'd0) ? 16'd1 : delay_ticks_ff;
   assign count_next = (wait_count_ff == WAIT_MAX) ? wait_count_ff
                                                   : wait_count_ff + 16'd1;

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      wait_count_in = wait_count_ff;
      op_kind_in    = op_kind_ff;
      ack_choice_in = ack_choice_ff;
      ack_flag_in   = ack_flag_ff;
      scl_low_in    = scl_low_ff;
      sda_low_in    = sda_low_ff;
      read_reg_in   = read_reg_ff;
      done_in       = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // New commands are taken only here; a command while busy is dropped.
         if (req_cmd_valid) begin
            op_kind_in    = op_type'(req_operation);
            shift_byte_in = (op_type'(req_operation) == OP_WRITE) ? req_write_data : 8'd0;
            ack_choice_in = req_send_ack;
            bit_index_in  = 4'd0;
            wait_count_in = 16'd0;
            case (op_type'(req_operation))
               OP_START: begin
                  phase_in   = PH_ST_A;
                  scl_low_in = 1'b0;
                  sda_low_in = 1'b0;
               end
               OP_STOP: begin
                  // Only SDA moves here; SCL keeps whatever drive it had.
                  phase_in   = PH_SP_A;
                  sda_low_in = 1'b1;
               end
               default: begin
                  phase_in   = PH_BSET;
                  scl_low_in = 1'b1;
                  sda_low_in = slot_sda_pull(op_type'(req_operation), 4'd0,
                                             shift_byte_in, req_send_ack);
               end
            endcase
         end
      end else if (stretch && !req_scl_sense) begin
         wait_count_in = 16'd0;
      end else begin
         wait_count_in = count_next;
         if (count_next >= limit) begin
            wait_count_in = 16'd0;
            case (phase_ff)
               PH_ST_A: begin
                  phase_in   = PH_ST_B;
                  sda_low_in = 1'b1;
               end
               PH_ST_B: begin
                  phase_in   = PH_ST_C;
                  scl_low_in = 1'b1;
               end
               PH_SP_A: begin
                  phase_in   = PH_SP_B;
                  scl_low_in = 1'b0;
               end
               PH_SP_B: begin
                  phase_in   = PH_SP_C;
                  sda_low_in = 1'b0;
               end
               PH_BSET: begin
                  phase_in   = PH_BHIGH;
                  scl_low_in = 1'b0;
               end
               PH_BHIGH: begin
                  // SDA is sampled at the end of the high phase.
                  if (op_kind_ff == OP_WRITE && bit_index_ff >= ACK_SLOT) begin
                     ack_flag_in = ~req_sda_sense;
                  end
                  if (op_kind_ff == OP_READ && bit_index_ff < ACK_SLOT) begin
                     shift_byte_in = {shift_byte_ff[6:0], req_sda_sense};
                  end
                  phase_in   = PH_BLOW;
                  scl_low_in = 1'b1;
               end
               PH_BLOW: begin
                  if (bit_index_ff >= ACK_SLOT) begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                     if (op_kind_ff == OP_READ) begin
                        read_reg_in = shift_byte_ff;
                     end
                  end else begin
                     bit_index_in = bit_index_ff + 4'd1;
                     phase_in     = PH_BSET;
                     scl_low_in   = 1'b1;
                     sda_low_in   = slot_sda_pull(op_kind_ff, bit_index_in,
                                                  shift_byte_ff, ack_choice_ff);
                  end
               end
               default: begin
                  // Last phase of a start or a stop: the lines stay as they are.
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
                  if (op_kind_ff == OP_READ) begin
                     read_reg_in = shift_byte_ff;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_index_ff   <= 4'd0;
         shift_byte_ff  <= 8'd0;
         wait_count_ff  <= 16'd0;
         op_kind_ff     <= OP_START;
         ack_choice_ff  <= 1'b0;
         ack_flag_ff    <= 1'b0;
         scl_low_ff     <= 1'b0;
         sda_low_ff     <= 1'b0;
         read_reg_ff    <= 8'd0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         delay_ticks_ff <= RST_DELAY;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff      <= phase_in;
            bit_index_ff  <= bit_index_in;
            shift_byte_ff <= shift_byte_in;
            wait_count_ff <= wait_count_in;
            op_kind_ff    <= op_kind_in;
            ack_choice_ff <= ack_choice_in;
            ack_flag_ff   <= ack_flag_in;
            scl_low_ff    <= scl_low_in;
            sda_low_ff    <= sda_low_in;
            read_reg_ff   <= read_reg_in;
            done_ff       <= done_in;
         end
         if (csr_write_enable) begin
            delay_ticks_ff <= csr_write_data;
         end
      end
   end

   // The state after the last accepted tick is the result word itself.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_pull_low = scl_low_ff;
   assign rsp_sda_pull_low = sda_low_ff;
   assign rsp_busy_res     = (phase_ff != PH_IDLE);
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = read_reg_ff;
   assign rsp_ack_received = ack_flag_ff;

   // A finished command always leaves the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (phase_ff == PH_IDLE))
      else $error("done flagged while a command is still running");

   // Every accepted tick yields a result word in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result word");

   // The phase counter is cleared whenever the engine is idle.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (wait_count_ff == 16'd0))
      else $error("phase counter not cleared while idle");

   // A stalled result holds the engine state.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(phase_ff) && $stable(wait_count_ff))
      else $error("engine state moved while the result was stalled");

endmodule

`default_nettype wire
